### src/qoi_enc_pkg.sv
// ----------------------------------------------------------------------------
// QOI encoder package
// Shared types, constants and the color hash used by the QOI encoder blocks.
// ----------------------------------------------------------------------------
package qoi_enc_pkg;

  localparam int unsigned CMD_QUEUE_DEPTH = 4;
  localparam int unsigned MAX_BYTES       = 6;
  localparam int unsigned BYTE_CNT_W      = 3;
  localparam int unsigned BYTE_IDX_W      = 3;
  localparam int unsigned HASH_W          = 6;
  localparam int unsigned TABLE_DEPTH     = 64;

  localparam logic [5:0] RUN_LIMIT   = 6'd62;
  localparam logic [7:0] OP_DIFF     = 8'h40;
  localparam logic [7:0] OP_LUMA     = 8'h80;
  localparam logic [7:0] OP_RUN_BIAS = 8'd191;
  localparam logic [7:0] OP_RUN_FULL = 8'hFD;
  localparam logic [7:0] OP_RGB      = 8'hFE;
  localparam logic [7:0] OP_RGBA     = 8'hFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  localparam pixel_t RESET_PIXEL = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd255};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       start_of_image;
    logic       end_of_image;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_pixel;
  } out_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [BYTE_CNT_W-1:0]     count;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [HASH_W-1:0] hash_of(pixel_t p);
    logic [11:0] sum;
    sum = 12'(p.red) * 12'd3 + 12'(p.green) * 12'd5 +
          12'(p.blue) * 12'd7 + 12'(p.alpha) * 12'd11;
    return sum[HASH_W-1:0];
  endfunction

endpackage

### src/qoi_image_encoder_top.sv
// ----------------------------------------------------------------------------
// QOI image encoder
// Encodes a stream of RGBA pixels into QOI chunk bytes.
// ----------------------------------------------------------------------------
// A pixel is taken in every cycle while full is low; the front end looks up
// the 64-entry recent pixel table, classifies the pixel and hands the whole
// group of chunk bytes to a short command queue. The back end delivers one
// byte per cycle while pop is high and bytes are queued, so the sustained pixel
// rate is one pixel per cycle for runs, index and diff chunks, and lower where
// a pixel causes more than one byte (two for luma, four for RGB, five for RGBA,
// plus one when a pending run is flushed), set by the single byte output port.
// The first byte of a pixel passes the front end register, a queue slot and the
// output register before it reaches the result ports. The table is cleared
// at once on reset and on start_of_image, so no clearing pass is needed.
module qoi_image_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = qoi_enc_pkg::CMD_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  qoi_enc_pkg::in_t  in_pixel,
  output logic              empty,
  input  logic              pop,
  output qoi_enc_pkg::out_t out_chunk
);

  logic                    cmd_push;
  logic                    cmd_pop;
  qoi_enc_pkg::cmd_t       cmd_in;
  qoi_enc_pkg::cmd_t       cmd_out;
  qoi_enc_pkg::fifo_stat_t cmd_stat;

  qoi_enc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_pixel (in_pixel),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_stat (cmd_stat)
  );

  qoi_enc_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_cmd (cmd_in),
    .rd_en  (cmd_pop),
    .rd_cmd (cmd_out),
    .stat   (cmd_stat)
  );

  qoi_enc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_out),
    .cmd_stat  (cmd_stat),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .out_chunk (out_chunk)
  );

endmodule

### src/qoi_enc_front.sv
// ----------------------------------------------------------------------------
// QOI encoder front end
// Accepts pixels, looks up the recent pixel table and classifies each pixel
// into the bytes of its chunks, keeping the previous pixel and run state.
// ----------------------------------------------------------------------------
module qoi_enc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  qoi_enc_pkg::in_t       in_pixel,
  output logic                   cmd_push,
  output qoi_enc_pkg::cmd_t      cmd,
  input  qoi_enc_pkg::fifo_stat_t cmd_stat
);

  qoi_enc_pkg::pixel_t table_mem [qoi_enc_pkg::TABLE_DEPTH];
  logic [qoi_enc_pkg::TABLE_DEPTH-1:0] valid_r, valid_nxt;

  logic                                b_valid_r;
  qoi_enc_pkg::in_t                    b_pix_r;
  logic [qoi_enc_pkg::HASH_W-1:0]      b_slot_r;
  qoi_enc_pkg::pixel_t                 rd_data_r;
  qoi_enc_pkg::pixel_t                 prev_r, prev_nxt;
  logic [5:0]                          run_r, run_nxt;

  qoi_enc_pkg::pixel_t                 in_pix;
  logic [qoi_enc_pkg::HASH_W-1:0]      in_slot;
  logic                                accept;
  logic                                b_move;

  qoi_enc_pkg::pixel_t                 cur;
  qoi_enc_pkg::pixel_t                 prev_eff;
  qoi_enc_pkg::pixel_t                 entry;
  logic [5:0]                          run_eff;
  logic signed [8:0]                   dr, dg, db;
  logic signed [9:0]                   rg, bg;
  logic                                diff_ok, luma_ok;
  logic [qoi_enc_pkg::MAX_BYTES-1:0][7:0] bytes;
  logic [qoi_enc_pkg::BYTE_CNT_W-1:0]  n;

  assign in_pix = '{red: in_pixel.red, green: in_pixel.green,
                    blue: in_pixel.blue, alpha: in_pixel.alpha};
  assign in_slot = qoi_enc_pkg::hash_of(in_pix);
  assign cur = '{red: b_pix_r.red, green: b_pix_r.green,
                 blue: b_pix_r.blue, alpha: b_pix_r.alpha};

  assign b_move = b_valid_r && ((n == '0) || !cmd_stat.full);
  assign full   = b_valid_r && !b_move;
  assign accept = push && !full;

  assign cmd_push  = b_move && (n != '0);
  assign cmd.bytes = bytes;
  assign cmd.count = n;

  assign prev_eff = b_pix_r.start_of_image ? qoi_enc_pkg::RESET_PIXEL : prev_r;
  assign run_eff  = b_pix_r.start_of_image ? 6'd0 : run_r;
  assign entry    = (b_pix_r.start_of_image || !valid_r[b_slot_r]) ? '0 : rd_data_r;

  assign dr = $signed({1'b0, cur.red})   - $signed({1'b0, prev_eff.red});
  assign dg = $signed({1'b0, cur.green}) - $signed({1'b0, prev_eff.green});
  assign db = $signed({1'b0, cur.blue})  - $signed({1'b0, prev_eff.blue});
  assign rg = $signed({dr[8], dr}) - $signed({dg[8], dg});
  assign bg = $signed({db[8], db}) - $signed({dg[8], dg});

  assign diff_ok = (dr >= -9'sd2) && (dr <= 9'sd1) && (dg >= -9'sd2) && (dg <= 9'sd1) &&
                   (db >= -9'sd2) && (db <= 9'sd1);
  assign luma_ok = (dg >= -9'sd32) && (dg <= 9'sd31) && (rg >= -10'sd8) && (rg <= 10'sd7) &&
                   (bg >= -10'sd8) && (bg <= 10'sd7);

  always_comb begin
    bytes   = '0;
    n       = '0;
    run_nxt = run_eff;
    if (b_pix_r.start_of_image && (run_r != 6'd0)) begin
      bytes[n] = qoi_enc_pkg::OP_RUN_BIAS + {2'b00, run_r};
      n        = n + 3'd1;
    end
    if (cur == prev_eff) begin
      run_nxt = run_eff + 6'd1;
      if (run_nxt == qoi_enc_pkg::RUN_LIMIT) begin
        bytes[n] = qoi_enc_pkg::OP_RUN_FULL;
        n        = n + 3'd1;
        run_nxt  = 6'd0;
      end
    end else begin
      if (run_eff != 6'd0) begin
        bytes[n] = qoi_enc_pkg::OP_RUN_BIAS + {2'b00, run_eff};
        n        = n + 3'd1;
      end
      run_nxt = 6'd0;
      if (entry == cur) begin
        bytes[n] = {2'b00, b_slot_r};
        n        = n + 3'd1;
      end else if (cur.alpha == prev_eff.alpha) begin
        if (diff_ok) begin
          bytes[n] = qoi_enc_pkg::OP_DIFF |
                     {2'b00, dr[1:0] + 2'd2, dg[1:0] + 2'd2, db[1:0] + 2'd2};
          n        = n + 3'd1;
        end else if (luma_ok) begin
          bytes[n] = qoi_enc_pkg::OP_LUMA | {2'b00, dg[5:0] + 6'd32};
          n        = n + 3'd1;
          bytes[n] = {rg[3:0] + 4'd8, bg[3:0] + 4'd8};
          n        = n + 3'd1;
        end else begin
          bytes[n] = qoi_enc_pkg::OP_RGB;
          n        = n + 3'd1;
          bytes[n] = cur.red;
          n        = n + 3'd1;
          bytes[n] = cur.green;
          n        = n + 3'd1;
          bytes[n] = cur.blue;
          n        = n + 3'd1;
        end
      end else begin
        bytes[n] = qoi_enc_pkg::OP_RGBA;
        n        = n + 3'd1;
        bytes[n] = cur.red;
        n        = n + 3'd1;
        bytes[n] = cur.green;
        n        = n + 3'd1;
        bytes[n] = cur.blue;
        n        = n + 3'd1;
        bytes[n] = cur.alpha;
        n        = n + 3'd1;
      end
    end
    if (b_pix_r.end_of_image && (run_nxt != 6'd0)) begin
      bytes[n] = qoi_enc_pkg::OP_RUN_BIAS + {2'b00, run_nxt};
      n        = n + 3'd1;
      run_nxt  = 6'd0;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    prev_nxt  = prev_r;
    if (b_move) begin
      if (b_pix_r.start_of_image) begin
        valid_nxt = '0;
      end
      valid_nxt[b_slot_r] = 1'b1;
      prev_nxt            = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      valid_r   <= '0;
      prev_r    <= qoi_enc_pkg::RESET_PIXEL;
      run_r     <= 6'd0;
    end else begin
      valid_r <= valid_nxt;
      prev_r  <= prev_nxt;
      if (b_move) begin
        run_r <= run_nxt;
      end
      if (accept) begin
        b_valid_r <= 1'b1;
      end else if (b_move) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      table_mem[b_slot_r] <= cur;
    end
    if (accept) begin
      b_pix_r  <= in_pixel;
      b_slot_r <= in_slot;
      if (b_move && (b_slot_r == in_slot)) begin
        rd_data_r <= cur;
      end else begin
        rd_data_r <= table_mem[in_slot];
      end
    end
  end

endmodule

### src/qoi_enc_cmd_fifo.sv
// ----------------------------------------------------------------------------
// QOI encoder command queue
// Short first-in first-out queue of classified chunk byte groups.
// ----------------------------------------------------------------------------
module qoi_enc_cmd_fifo #(
  parameter int unsigned DEPTH = qoi_enc_pkg::CMD_QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  qoi_enc_pkg::cmd_t       wr_cmd,
  input  logic                    rd_en,
  output qoi_enc_pkg::cmd_t       rd_cmd,
  output qoi_enc_pkg::fifo_stat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  qoi_enc_pkg::cmd_t slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);
  assign do_wr  = wr_en && !stat.full;
  assign do_rd  = rd_en && !stat.empty;
  assign rd_cmd = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

### src/qoi_enc_back.sv
// ----------------------------------------------------------------------------
// QOI encoder back end
// Serializes queued chunk byte groups into single bytes with an output
// register on the result side.
// ----------------------------------------------------------------------------
module qoi_enc_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  qoi_enc_pkg::cmd_t       cmd,
  input  qoi_enc_pkg::fifo_stat_t cmd_stat,
  output logic                    cmd_pop,
  output logic                    empty,
  input  logic                    pop,
  output qoi_enc_pkg::out_t       out_chunk
);

  logic [qoi_enc_pkg::BYTE_IDX_W-1:0] idx_r, idx_nxt;
  logic                               out_valid_r, out_valid_nxt;
  qoi_enc_pkg::out_t                  out_r;
  logic                               load;
  logic                               is_last;

  assign empty     = !out_valid_r;
  assign out_chunk = out_r;
  assign load      = !cmd_stat.empty && (!out_valid_r || pop);
  assign is_last   = (idx_r == (cmd.count - 3'd1));
  assign cmd_pop   = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = is_last ? '0 : idx_r + 3'd1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.out_byte      <= cmd.bytes[idx_r];
      out_r.last_of_pixel <= is_last;
    end
  end

endmodule
